// ===== hdl/pdri_pkg.sv =====
// ----------------------------------------------------------------------------
// Pose dead-reckoning integrator package
// Shared types, constants and small functions for the pose integrator.
// ----------------------------------------------------------------------------
package pdri_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 16;
    localparam int TRIG_FRAC_W = 30;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int ATAN_IDX_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLONOMIC = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME = 1'd1;

    localparam logic [STEP_W-1:0] STEP_TIME_RESET = 16'd655;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b1;

    // Quadrant codes of the angle in turns.
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Start value of the rotation vector, which cancels the CORDIC gain (Q2.30).
    localparam logic signed [DATA_W-1:0] CORDIC_X0 = 32'sd652032874;

    // Angle reduction. The whole-degree part is biased by 183 full circles so
    // that it is never negative, then reduced by a reciprocal multiply.
    localparam logic [17:0] WRAP_BIAS     = 18'd65880;
    localparam logic [18:0] RECIP_360     = 19'd372828;
    localparam logic [8:0]  DEG_FULL      = 9'd360;
    localparam logic [25:0] RECIP_45      = 26'd47721859;
    localparam logic [5:0]  DIV_45        = 6'd45;
    localparam logic [19:0] RECIP_45_FRAC = 20'd745655;

    localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] linear_speed;
        logic signed [DATA_W-1:0] angular_speed;
        logic signed [DATA_W-1:0] direction_offset;
        logic signed [DATA_W-1:0] new_x;
        logic signed [DATA_W-1:0] new_y;
        logic signed [DATA_W-1:0] new_heading;
    } pdri_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pose_x;
        logic signed [DATA_W-1:0] pose_y;
        logic signed [DATA_W-1:0] pose_heading;
    } pdri_pose_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_HEAD,
        ST_HEAD_UPD,
        ST_ANG_RED,
        ST_ANG_REM,
        ST_ANG_DIV,
        ST_ANG_MOD,
        ST_ANG_TURN,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_Y_UPD,
        ST_DONE
    } pdri_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_HEAD,
        OP_HEAD_UPD,
        OP_ANG_RED,
        OP_ANG_REM,
        OP_ANG_DIV,
        OP_ANG_MOD,
        OP_ANG_TURN,
        OP_CORDIC,
        OP_MUL_X,
        OP_MUL_Y,
        OP_Y_UPD
    } pdri_op_t;

    typedef struct packed {
        logic                  capture;
        logic                  load_pose;
        logic                  out_load;
        pdri_op_t              op;
        logic [ATAN_IDX_W-1:0] iter;
    } pdri_cmd_t;

    // Arctangent of 2^-i in 2^-32 turns.
    function automatic logic signed [DATA_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [DATA_W-1:0] val;
        case (idx)
            5'd0:    val = 32'sd536870912;
            5'd1:    val = 32'sd316933406;
            5'd2:    val = 32'sd167458907;
            5'd3:    val = 32'sd85004756;
            5'd4:    val = 32'sd42667331;
            5'd5:    val = 32'sd21354465;
            5'd6:    val = 32'sd10679838;
            5'd7:    val = 32'sd5340245;
            5'd8:    val = 32'sd2670163;
            5'd9:    val = 32'sd1335087;
            5'd10:   val = 32'sd667544;
            5'd11:   val = 32'sd333772;
            5'd12:   val = 32'sd166886;
            5'd13:   val = 32'sd83443;
            5'd14:   val = 32'sd41722;
            5'd15:   val = 32'sd20861;
            5'd16:   val = 32'sd10430;
            5'd17:   val = 32'sd5215;
            5'd18:   val = 32'sd2608;
            5'd19:   val = 32'sd1304;
            5'd20:   val = 32'sd652;
            5'd21:   val = 32'sd326;
            5'd22:   val = 32'sd163;
            5'd23:   val = 32'sd81;
            5'd24:   val = 32'sd41;
            5'd25:   val = 32'sd20;
            5'd26:   val = 32'sd10;
            5'd27:   val = 32'sd5;
            5'd28:   val = 32'sd3;
            5'd29:   val = 32'sd1;
            5'd30:   val = 32'sd1;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_HI)
        begin
            res = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            res = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/pose_dead_reckoning_integrator_core.sv =====
// ----------------------------------------------------------------------------
// Pose dead-reckoning integrator
// Integrates a planar pose from speed items, or loads it, and returns the
// pose after every item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  item      in         item_valid/item_stall  pdri_item_t (kind, speeds, load pose)
//  pose      out        pose_valid/pose_stall  pdri_pose_t (x, y, heading)
//  cfg       in         cfg_write              cfg_index, cfg_data
//
//  A step item runs through the heading multiply, the angle reduction
//  stages, the single-rotation CORDIC loop and the shared multiplier; a
//  load item goes straight to the result stage. No new item is accepted
//  until the block has returned to idle.
//  Reset clears the pose to zero, holonomic mode off and the time step to 655.
//  A stalled result holds in its output register; the block then finishes
//  the next item up to the result stage and waits there.
// ----------------------------------------------------------------------------
module pose_dead_reckoning_integrator_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  pdri_pkg::pdri_item_t               item,
    output logic                               pose_valid,
    input  logic                               pose_stall,
    output pdri_pkg::pdri_pose_t               pose,
    input  logic                               cfg_write,
    input  logic [pdri_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pdri_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pdri_pkg::pdri_cmd_t cmd;

    pdri_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .cmd        (cmd)
    );

    pdri_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose)
    );

endmodule

// ===== hdl/pdri_datapath.sv =====
// ----------------------------------------------------------------------------
// Pose integrator datapath
// Pose and configuration registers, the shared multiplier, the angle
// reduction stages and the iterative CORDIC rotator.
// ----------------------------------------------------------------------------
module pdri_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pdri_pkg::pdri_cmd_t                    cmd,
    input  pdri_pkg::pdri_item_t                   item,
    input  logic                                   cfg_write,
    input  logic [pdri_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pdri_pkg::CFG_DATA_W-1:0]        cfg_data,
    output pdri_pkg::pdri_pose_t                   pose
);

    localparam logic signed [64:0] RND_HALF_STEP = 65'sd32768;
    localparam logic signed [64:0] RND_HALF_TRIG = 65'sd536870912;

    // Registers with reset.
    logic                                   holonomic_reg, holonomic_next;
    logic [pdri_pkg::STEP_W-1:0]            step_time_reg, step_time_next;
    logic signed [pdri_pkg::DATA_W-1:0]     x_reg, x_next;
    logic signed [pdri_pkg::DATA_W-1:0]     y_reg, y_next;
    logic signed [pdri_pkg::DATA_W-1:0]     heading_reg, heading_next;

    // Working registers.
    logic signed [pdri_pkg::DATA_W-1:0]     lin_reg, lin_next;
    logic signed [pdri_pkg::DATA_W-1:0]     ang_reg, ang_next;
    logic signed [pdri_pkg::DATA_W-1:0]     off_reg, off_next;
    logic signed [64:0]                     prod_reg, prod_next;
    logic signed [pdri_pkg::DATA_W-1:0]     dist_reg, dist_next;
    logic [17:0]                            u_reg, u_next;
    logic [8:0]                             q_reg, q_next;
    logic [pdri_pkg::FRAC_W-1:0]            lo_reg, lo_next;
    logic [24:0]                            a_reg, a_next;
    logic [18:0]                            q1_reg, q1_next;
    logic [5:0]                             r1_reg, r1_next;
    logic signed [pdri_pkg::DATA_W-1:0]     cx_reg, cx_next;
    logic signed [pdri_pkg::DATA_W-1:0]     cy_reg, cy_next;
    logic signed [pdri_pkg::DATA_W-1:0]     z_reg, z_next;
    logic [1:0]                             quad_reg, quad_next;
    pdri_pkg::pdri_pose_t                   pose_reg, pose_next;

    // Combinational helpers.
    logic signed [pdri_pkg::DATA_W-1:0]     mul_a;
    logic signed [32:0]                     mul_b;
    logic signed [64:0]                     mul_p;
    logic signed [64:0]                     step_round;
    logic signed [pdri_pkg::DATA_W-1:0]     step_delta;
    logic signed [64:0]                     trig_round;
    logic signed [34:0]                     trig_delta;
    logic signed [32:0]                     heading_sum;
    logic signed [35:0]                     x_sum;
    logic signed [35:0]                     y_sum;
    logic signed [32:0]                     ang_sum;
    logic signed [16:0]                     ang_hi;
    logic [17:0]                            wrap_u;
    logic [36:0]                            q_prod;
    logic [17:0]                            rem_u;
    logic [50:0]                            q1_prod;
    logic [24:0]                            r1_full;
    logic [25:0]                            frac_prod;
    logic [12:0]                            frac;
    logic signed [pdri_pkg::DATA_W-1:0]     cos_v;
    logic signed [pdri_pkg::DATA_W-1:0]     sin_v;
    logic signed [pdri_pkg::DATA_W-1:0]     cx_sh;
    logic signed [pdri_pkg::DATA_W-1:0]     cy_sh;
    logic signed [pdri_pkg::DATA_W-1:0]     atan_val;

    // Shared multiplier: heading increment, distance, then distance times cos and sin.
    always_comb
    begin
        case (cmd.op)
            pdri_pkg::OP_MUL_HEAD:
            begin
                mul_a = ang_reg;
                mul_b = 33'($signed({1'b0, step_time_reg}));
            end
            pdri_pkg::OP_HEAD_UPD:
            begin
                mul_a = lin_reg;
                mul_b = 33'($signed({1'b0, step_time_reg}));
            end
            pdri_pkg::OP_MUL_Y:
            begin
                mul_a = dist_reg;
                mul_b = 33'(sin_v);
            end
            default:
            begin
                mul_a = dist_reg;
                mul_b = 33'(cos_v);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round half up, then drop the fraction of the step time or of the trig value.
    assign step_round  = prod_reg + RND_HALF_STEP;
    assign step_delta  = step_round[pdri_pkg::DATA_W+pdri_pkg::STEP_W-1:pdri_pkg::STEP_W];
    assign trig_round  = prod_reg + RND_HALF_TRIG;
    assign trig_delta  = trig_round[64:pdri_pkg::TRIG_FRAC_W];
    assign heading_sum = 33'(heading_reg) + 33'(step_delta);
    assign x_sum       = 36'(x_reg) + 36'(trig_delta);
    assign y_sum       = 36'(y_reg) + 36'(trig_delta);

    // Angle reduction modulo 360 degrees: the fraction bits pass through and
    // the whole-degree part is reduced on its own.
    assign ang_sum   = 33'(off_reg) + 33'(heading_reg);
    assign ang_hi    = ang_sum[32:pdri_pkg::FRAC_W];
    assign wrap_u    = 18'(ang_hi) + pdri_pkg::WRAP_BIAS;
    assign q_prod    = wrap_u * pdri_pkg::RECIP_360;
    assign rem_u     = u_reg - q_reg * pdri_pkg::DEG_FULL;

    // Turns = angle * 2^13 / 45, split into a quotient and a remainder part.
    assign q1_prod   = a_reg * pdri_pkg::RECIP_45;
    assign r1_full   = a_reg - q1_reg * pdri_pkg::DIV_45;
    assign frac_prod = r1_reg * pdri_pkg::RECIP_45_FRAC;
    assign frac      = frac_prod[24:12];

    // CORDIC micro-rotation.
    assign cx_sh    = cx_reg >>> cmd.iter;
    assign cy_sh    = cy_reg >>> cmd.iter;
    assign atan_val = pdri_pkg::atan_turns(cmd.iter);

    // Map the first-quadrant result back to the full circle.
    always_comb
    begin
        case (quad_reg)
            pdri_pkg::QUAD_1:
            begin
                cos_v = -cy_reg;
                sin_v = cx_reg;
            end
            pdri_pkg::QUAD_2:
            begin
                cos_v = -cx_reg;
                sin_v = -cy_reg;
            end
            pdri_pkg::QUAD_3:
            begin
                cos_v = cy_reg;
                sin_v = -cx_reg;
            end
            default:
            begin
                cos_v = cx_reg;
                sin_v = cy_reg;
            end
        endcase
    end

    always_comb
    begin
        holonomic_next = holonomic_reg;
        step_time_next = step_time_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        heading_next   = heading_reg;
        lin_next       = lin_reg;
        ang_next       = ang_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        dist_next      = dist_reg;
        u_next         = u_reg;
        q_next         = q_reg;
        lo_next        = lo_reg;
        a_next         = a_reg;
        q1_next        = q1_reg;
        r1_next        = r1_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        z_next         = z_reg;
        quad_next      = quad_reg;
        pose_next      = pose_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                pdri_pkg::CFG_HOLONOMIC: holonomic_next = cfg_data[0];
                pdri_pkg::CFG_STEP_TIME: step_time_next = cfg_data[pdri_pkg::STEP_W-1:0];
                default: ;
            endcase
        end

        if (cmd.capture)
        begin
            lin_next = item.linear_speed;
            ang_next = item.angular_speed;
            off_next = item.direction_offset;
        end

        if (cmd.load_pose)
        begin
            x_next       = item.new_x;
            y_next       = item.new_y;
            heading_next = item.new_heading;
        end

        case (cmd.op)
            pdri_pkg::OP_MUL_HEAD:
            begin
                prod_next = mul_p;
            end
            pdri_pkg::OP_HEAD_UPD:
            begin
                heading_next = pdri_pkg::sat32(40'(heading_sum));
                prod_next    = mul_p;
            end
            pdri_pkg::OP_ANG_RED:
            begin
                dist_next = step_delta;
                u_next    = wrap_u;
                q_next    = q_prod[35:27];
                lo_next   = ang_sum[pdri_pkg::FRAC_W-1:0];
            end
            pdri_pkg::OP_ANG_REM:
            begin
                a_next = {rem_u[8:0], lo_reg};
            end
            pdri_pkg::OP_ANG_DIV:
            begin
                q1_next = q1_prod[49:31];
            end
            pdri_pkg::OP_ANG_MOD:
            begin
                r1_next = r1_full[5:0];
            end
            pdri_pkg::OP_ANG_TURN:
            begin
                // The top two bits of the angle in turns select the quadrant.
                quad_next = q1_reg[18:17];
                z_next    = $signed({2'b00, q1_reg[16:0], frac});
                cx_next   = pdri_pkg::CORDIC_X0;
                cy_next   = '0;
            end
            pdri_pkg::OP_CORDIC:
            begin
                if (!z_reg[pdri_pkg::DATA_W-1])
                begin
                    cx_next = cx_reg - cy_sh;
                    cy_next = cy_reg + cx_sh;
                    z_next  = z_reg - atan_val;
                end
                else
                begin
                    cx_next = cx_reg + cy_sh;
                    cy_next = cy_reg - cx_sh;
                    z_next  = z_reg + atan_val;
                end
            end
            pdri_pkg::OP_MUL_X:
            begin
                prod_next = mul_p;
            end
            pdri_pkg::OP_MUL_Y:
            begin
                x_next    = pdri_pkg::sat32(40'(x_sum));
                prod_next = mul_p;
            end
            pdri_pkg::OP_Y_UPD:
            begin
                if (holonomic_reg)
                begin
                    y_next = pdri_pkg::sat32(40'(y_sum));
                end
            end
            default: ;
        endcase

        if (cmd.out_load)
        begin
            pose_next.pose_x       = x_reg;
            pose_next.pose_y       = y_reg;
            pose_next.pose_heading = heading_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holonomic_reg <= 1'b0;
            step_time_reg <= pdri_pkg::STEP_TIME_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            holonomic_reg <= holonomic_next;
            step_time_reg <= step_time_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg  <= lin_next;
        ang_reg  <= ang_next;
        off_reg  <= off_next;
        prod_reg <= prod_next;
        dist_reg <= dist_next;
        u_reg    <= u_next;
        q_reg    <= q_next;
        lo_reg   <= lo_next;
        a_reg    <= a_next;
        q1_reg   <= q1_next;
        r1_reg   <= r1_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        pose_reg <= pose_next;
    end

    assign pose = pose_reg;

endmodule

// ===== hdl/pdri_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pose integrator controller
// Sequences one item through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module pdri_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_kind,
    output logic                   item_stall,
    output logic                   pose_valid,
    input  logic                   pose_stall,
    output pdri_pkg::pdri_cmd_t    cmd
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int IDX_W = pdri_pkg::ATAN_IDX_W;

    pdri_pkg::pdri_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pose_valid_reg, pose_valid_next;
    logic                  accept;
    logic                  cnt_last;
    logic                  out_free;

    assign accept   = item_valid && !item_stall;
    assign cnt_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));
    assign out_free = !pose_valid_reg || !pose_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            pdri_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_kind == pdri_pkg::KIND_LOAD)
                    begin
                        state_next = pdri_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = pdri_pkg::ST_MUL_HEAD;
                    end
                end
            end
            pdri_pkg::ST_MUL_HEAD: state_next = pdri_pkg::ST_HEAD_UPD;
            pdri_pkg::ST_HEAD_UPD: state_next = pdri_pkg::ST_ANG_RED;
            pdri_pkg::ST_ANG_RED:  state_next = pdri_pkg::ST_ANG_REM;
            pdri_pkg::ST_ANG_REM:  state_next = pdri_pkg::ST_ANG_DIV;
            pdri_pkg::ST_ANG_DIV:  state_next = pdri_pkg::ST_ANG_MOD;
            pdri_pkg::ST_ANG_MOD:  state_next = pdri_pkg::ST_ANG_TURN;
            pdri_pkg::ST_ANG_TURN:
            begin
                state_next = pdri_pkg::ST_CORDIC;
                cnt_next   = '0;
            end
            pdri_pkg::ST_CORDIC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = pdri_pkg::ST_MUL_X;
                end
            end
            pdri_pkg::ST_MUL_X: state_next = pdri_pkg::ST_MUL_Y;
            pdri_pkg::ST_MUL_Y: state_next = pdri_pkg::ST_Y_UPD;
            pdri_pkg::ST_Y_UPD: state_next = pdri_pkg::ST_DONE;
            pdri_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = pdri_pkg::ST_IDLE;
                end
            end
            default: state_next = pdri_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        item_stall    = (state_reg != pdri_pkg::ST_IDLE);
        cmd.capture   = accept;
        cmd.load_pose = accept && (item_kind == pdri_pkg::KIND_LOAD);
        cmd.out_load  = (state_reg == pdri_pkg::ST_DONE) && out_free;
        cmd.iter      = IDX_W'(cnt_reg);
        case (state_reg)
            pdri_pkg::ST_MUL_HEAD: cmd.op = pdri_pkg::OP_MUL_HEAD;
            pdri_pkg::ST_HEAD_UPD: cmd.op = pdri_pkg::OP_HEAD_UPD;
            pdri_pkg::ST_ANG_RED:  cmd.op = pdri_pkg::OP_ANG_RED;
            pdri_pkg::ST_ANG_REM:  cmd.op = pdri_pkg::OP_ANG_REM;
            pdri_pkg::ST_ANG_DIV:  cmd.op = pdri_pkg::OP_ANG_DIV;
            pdri_pkg::ST_ANG_MOD:  cmd.op = pdri_pkg::OP_ANG_MOD;
            pdri_pkg::ST_ANG_TURN: cmd.op = pdri_pkg::OP_ANG_TURN;
            pdri_pkg::ST_CORDIC:   cmd.op = pdri_pkg::OP_CORDIC;
            pdri_pkg::ST_MUL_X:    cmd.op = pdri_pkg::OP_MUL_X;
            pdri_pkg::ST_MUL_Y:    cmd.op = pdri_pkg::OP_MUL_Y;
            pdri_pkg::ST_Y_UPD:    cmd.op = pdri_pkg::OP_Y_UPD;
            default:               cmd.op = pdri_pkg::OP_NONE;
        endcase
    end

    // The result register is refilled only once the previous item has been taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            pose_valid_next = 1'b1;
        end
        else if (!pose_stall)
        begin
            pose_valid_next = 1'b0;
        end
        else
        begin
            pose_valid_next = pose_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pdri_pkg::ST_IDLE;
            cnt_reg        <= '0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pose_valid_reg <= pose_valid_next;
        end
    end

    assign pose_valid = pose_valid_reg;

    ap_load_skips_math: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item_kind == pdri_pkg::KIND_LOAD) |=> state_reg == pdri_pkg::ST_DONE)
        else $error("load item did not go straight to the result stage");

    ap_cordic_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pdri_pkg::ST_ANG_TURN |=>
            state_reg == pdri_pkg::ST_CORDIC && cnt_reg == '0)
        else $error("CORDIC did not start from its first rotation");

    ap_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pdri_pkg::ST_CORDIC && !cnt_last |=>
            state_reg == pdri_pkg::ST_CORDIC && cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))
        else $error("CORDIC rotation count skipped or stopped early");

    ap_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid_reg) |-> $past(state_reg == pdri_pkg::ST_DONE))
        else $error("result became valid outside the result stage");

endmodule
